// ===== hw/rtl/cld_pkg.sv =====
// Package for the content-length deframer: widths, line-parser phase and
// line-kind types, key text and character class helpers.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package cld_pkg;

	localparam int LENGTH_BITS = 32;
	localparam int KEY_LEN     = 14;
	localparam int IDX_BITS    = $clog2(KEY_LEN + 1);
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
	localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_COLON = 8'h3A;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;

	typedef enum logic [2:0] {
		PH_NAME_LEAD,
		PH_NAME_BODY,
		PH_NAME_TRAIL,
		PH_NAME_FAIL,
		PH_VAL_LEAD,
		PH_VAL_DIGITS,
		PH_VAL_DONE,
		PH_IGNORE
	} phase_t;

	typedef enum logic [1:0] {
		KIND_NONE,
		KIND_CR,
		KIND_TEXT
	} kind_t;

	typedef struct packed {
		logic [7:0] data;
		logic       last;
	} item_t;

	typedef struct packed {
		logic full;
		logic empty;
	} queue_status_t;

	function automatic logic is_blank(input logic [7:0] c);
		return (c == 8'h20) || (c == 8'h09) || (c == 8'h0B) || (c == 8'h0C) ||
			(c == 8'h0D);
	endfunction

	function automatic logic is_digit(input logic [7:0] c);
		return (c >= CH_ZERO) && (c <= CH_NINE);
	endfunction

	// "Content-Length", one character per match position
	function automatic logic [7:0] key_char(input logic [IDX_BITS-1:0] idx);
		logic [7:0] ch;
		case (idx)
			4'd0:    ch = 8'h43; // C
			4'd1:    ch = 8'h6F; // o
			4'd2:    ch = 8'h6E; // n
			4'd3:    ch = 8'h74; // t
			4'd4:    ch = 8'h65; // e
			4'd5:    ch = 8'h6E; // n
			4'd6:    ch = 8'h74; // t
			4'd7:    ch = 8'h2D; // -
			4'd8:    ch = 8'h4C; // L
			4'd9:    ch = 8'h65; // e
			4'd10:   ch = 8'h6E; // n
			4'd11:   ch = 8'h67; // g
			4'd12:   ch = 8'h74; // t
			4'd13:   ch = 8'h68; // h
			default: ch = 8'h00;
		endcase
		return ch;
	endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/cld_parser.sv =====
// Front end: parses header lines, tracks the pending length and tags
// payload bytes. Depends on cld_pkg.
`timescale 1ns / 1ps
`default_nettype none

module cld_parser
	import cld_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	input  wire logic [7:0] in_byte,
	output logic            wr,
	output item_t           wr_item
);

	logic                   in_payload_q, in_payload_d;
	phase_t                 phase_q, phase_d;
	kind_t                  kind_q, kind_d;
	logic [IDX_BITS-1:0]    idx_q, idx_d;
	logic [LENGTH_BITS-1:0] acc_q, acc_d;
	logic                   has_digit_q, has_digit_d;
	logic                   ovf_q, ovf_d;
	logic [LENGTH_BITS-1:0] committed_q, committed_d;
	logic [LENGTH_BITS-1:0] remaining_q, remaining_d;

	logic [LENGTH_BITS-1:0] rem_dec;
	logic [LENGTH_BITS+3:0] acc_ext;
	logic [LENGTH_BITS+3:0] acc_x10;
	logic                   digit_ovf;
	logic                   new_line;

	assign rem_dec = remaining_q - 1'b1;
	assign acc_ext = {4'b0, acc_q};
	// acc*10 + digit, overflow when anything lands above the length width
	assign acc_x10 = (acc_ext << 3) + (acc_ext << 1) +
		{{(LENGTH_BITS){1'b0}}, in_byte[3:0]};
	assign digit_ovf = acc_x10[LENGTH_BITS+3:LENGTH_BITS] != 4'b0;

	assign wr           = in_valid && in_payload_q;
	assign wr_item.data = in_byte;
	assign wr_item.last = rem_dec == '0;

	always_comb begin
		in_payload_d = in_payload_q;
		phase_d      = phase_q;
		kind_d       = kind_q;
		idx_d        = idx_q;
		acc_d        = acc_q;
		has_digit_d  = has_digit_q;
		ovf_d        = ovf_q;
		committed_d  = committed_q;
		remaining_d  = remaining_q;
		new_line     = 1'b0;

		if (in_valid) begin
			if (in_payload_q) begin
				remaining_d = rem_dec;
				if (rem_dec == '0) begin
					in_payload_d = 1'b0;
					committed_d  = '0;
					new_line     = 1'b1;
				end
			end else if (in_byte == CH_LF) begin
				if (kind_q != KIND_TEXT) begin
					// an empty line, or a lone CR, closes the header block
					if (committed_q != '0) begin
						in_payload_d = 1'b1;
						remaining_d  = committed_q;
					end
				end else if (phase_q == PH_VAL_LEAD || phase_q == PH_VAL_DIGITS ||
						phase_q == PH_VAL_DONE) begin
					committed_d = (has_digit_q && !ovf_q) ? acc_q : '0;
				end
				new_line = 1'b1;
			end else begin
				kind_d = (kind_q == KIND_NONE && in_byte == CH_CR) ? KIND_CR : KIND_TEXT;
				case (phase_q)
					PH_NAME_LEAD, PH_NAME_BODY, PH_NAME_TRAIL, PH_NAME_FAIL: begin
						if (in_byte == CH_COLON) begin
							phase_d = (phase_q != PH_NAME_FAIL &&
								idx_q == IDX_BITS'(KEY_LEN)) ? PH_VAL_LEAD : PH_IGNORE;
						end else if (phase_q == PH_NAME_FAIL) begin
							phase_d = PH_NAME_FAIL;
						end else if (is_blank(in_byte)) begin
							if (phase_q == PH_NAME_BODY)
								phase_d = PH_NAME_TRAIL;
						end else if (phase_q == PH_NAME_TRAIL) begin
							phase_d = PH_NAME_FAIL;
						end else if (idx_q < IDX_BITS'(KEY_LEN) &&
								in_byte == key_char(idx_q)) begin
							idx_d   = idx_q + 1'b1;
							phase_d = PH_NAME_BODY;
						end else begin
							phase_d = PH_NAME_FAIL;
						end
					end
					PH_VAL_LEAD, PH_VAL_DIGITS: begin
						if (is_digit(in_byte)) begin
							has_digit_d = 1'b1;
							phase_d     = PH_VAL_DIGITS;
							if (!ovf_q) begin
								if (digit_ovf)
									ovf_d = 1'b1;
								else
									acc_d = acc_x10[LENGTH_BITS-1:0];
							end
						end else if (phase_q == PH_VAL_DIGITS || !is_blank(in_byte)) begin
							phase_d = PH_VAL_DONE;
						end
					end
					default: begin
					end
				endcase
			end

			if (new_line) begin
				phase_d     = PH_NAME_LEAD;
				kind_d      = KIND_NONE;
				idx_d       = '0;
				acc_d       = '0;
				has_digit_d = 1'b0;
				ovf_d       = 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_payload_q <= 1'b0;
			phase_q      <= PH_NAME_LEAD;
			kind_q       <= KIND_NONE;
			idx_q        <= '0;
			acc_q        <= '0;
			has_digit_q  <= 1'b0;
			ovf_q        <= 1'b0;
			committed_q  <= '0;
			remaining_q  <= '0;
		end else begin
			in_payload_q <= in_payload_d;
			phase_q      <= phase_d;
			kind_q       <= kind_d;
			idx_q        <= idx_d;
			acc_q        <= acc_d;
			has_digit_q  <= has_digit_d;
			ovf_q        <= ovf_d;
			committed_q  <= committed_d;
			remaining_q  <= remaining_d;
		end
	end

endmodule

`default_nettype wire

// ===== hw/rtl/cld_queue.sv =====
// Back end: short item queue between the parser and the result ports.
// Depends on cld_pkg.
`timescale 1ns / 1ps
`default_nettype none

module cld_queue
	import cld_pkg::*;
(
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  wr,
	input  wire item_t wr_item,
	input  wire logic  rd,
	output item_t      rd_item,
	output queue_status_t status
);

	item_t                entries [QUEUE_DEPTH];
	logic [QPTR_BITS-1:0] wr_ptr_q;
	logic [QPTR_BITS-1:0] rd_ptr_q;
	logic [QCNT_BITS-1:0] count_q;
	logic                 do_wr;
	logic                 do_rd;

	assign status.full  = count_q == QCNT_BITS'(QUEUE_DEPTH);
	assign status.empty = count_q == '0;
	assign do_wr        = wr && !status.full;
	assign do_rd        = rd && !status.empty;
	assign rd_item      = entries[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_wr)
			entries[wr_ptr_q] <= wr_item;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr)
				wr_ptr_q <= wr_ptr_q + 1'b1;
			if (do_rd)
				rd_ptr_q <= rd_ptr_q + 1'b1;
			if (do_wr && !do_rd)
				count_q <= count_q + 1'b1;
			else if (do_rd && !do_wr)
				count_q <= count_q - 1'b1;
		end
	end

endmodule

`default_nettype wire

// ===== hw/rtl/content_length_deframer.sv =====
// Content-length deframer top level: header parser feeding a four-item queue.
// Throughput one byte per cycle while not full; a payload byte is written to the
// queue, whose head drives the result ports; header bytes give no item.
// full rises only when the queue holds four unread items.
// arst_n clears to header mode, start of line, zero pending length, queue empty.
// Depends on cld_pkg, cld_parser, cld_queue.
`timescale 1ns / 1ps
`default_nettype none

module content_length_deframer
	import cld_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       push,
	output logic            full,
	input  wire logic [7:0] in_byte,
	input  wire logic       pop,
	output logic            empty,
	output logic [7:0]      payload_byte,
	output logic            payload_last
);

	logic          in_accept;
	logic          q_wr;
	item_t         q_wr_item;
	item_t         q_rd_item;
	queue_status_t q_status;

	assign full      = q_status.full;
	assign empty     = q_status.empty;
	assign in_accept = push && !q_status.full;

	cld_parser u_parser (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_accept),
		.in_byte  (in_byte),
		.wr       (q_wr),
		.wr_item  (q_wr_item)
	);

	cld_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr      (q_wr),
		.wr_item (q_wr_item),
		.rd      (pop),
		.rd_item (q_rd_item),
		.status  (q_status)
	);

	assign payload_byte = q_rd_item.data;
	assign payload_last = q_rd_item.last;

	// a payload item is only produced for an accepted byte
	a_wr_needs_accept: assert property (@(posedge clk) disable iff (!arst_n)
		q_wr |-> in_accept)
		else $error("queue write without accepted byte");

	a_not_full_and_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!(q_status.full && q_status.empty))
		else $error("queue full and empty together");

	a_write_shows: assert property (@(posedge clk) disable iff (!arst_n)
		(q_wr && !(pop && !q_status.empty)) |=> !q_status.empty)
		else $error("written item not visible");

	a_read_frees: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && !q_status.empty && !q_wr) |=> !q_status.full)
		else $error("queue still full after read");

endmodule

`default_nettype wire

// ===== dv/content_length_deframer_tb.sv =====
// Testbench for content_length_deframer: header-framed byte streams, an in-bench
// predictor of the payload items and a field-by-field scoreboard under random idling.
// Depends on cld_pkg and the content_length_deframer RTL.
`timescale 1ns / 1ps

module content_length_deframer_tb;
	import cld_pkg::*;

	localparam int WATCHDOG_LIMIT = 2000;
	localparam int RANDOM_BYTES   = 350;
	localparam int IDLE_PCT       = 29;

	localparam logic [7:0] B_SP  = 8'h20;
	localparam logic [7:0] B_TAB = 8'h09;
	localparam logic [7:0] B_VT  = 8'h0B;
	localparam logic [7:0] B_FF  = 8'h0C;

	localparam logic [8*KEY_LEN-1:0] CL_KEY = "Content-Length";

	logic       clk     = 1'b0;
	logic       arst_n  = 1'b0;
	logic       push    = 1'b0;
	logic [7:0] in_byte = 8'h00;
	logic       pop     = 1'b0;
	logic       full;
	logic       empty;
	logic [7:0] payload_byte;
	logic       payload_last;

	content_length_deframer dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.push         (push),
		.full         (full),
		.in_byte      (in_byte),
		.pop          (pop),
		.empty        (empty),
		.payload_byte (payload_byte),
		.payload_last (payload_last)
	);

	logic [7:0] byte_stream [$];
	item_t      expected_payload [$];
	int         mismatches     = 0;
	int         accepted_bytes = 0;
	int         quiet_cycles   = 0;
	logic       calm;

	// no idling on either side through this stretch of the stream
	assign calm = (accepted_bytes >= 300) && (accepted_bytes < 500);

	// predictor state
	logic                   pl_mode   = 1'b0;
	phase_t                 ph        = PH_NAME_LEAD;
	kind_t                  kind      = KIND_NONE;
	logic [IDX_BITS-1:0]    key_pos   = '0;
	logic [LENGTH_BITS-1:0] acc       = '0;
	logic                   saw_digit = 1'b0;
	logic                   ovf       = 1'b0;
	logic [LENGTH_BITS-1:0] pend_len  = '0;
	logic [LENGTH_BITS-1:0] left      = '0;

	initial begin
		forever #5 clk = ~clk;
	end

	task automatic note_mismatch(input string msg);
		mismatches++;
		if (mismatches <= 50)
			$display("MISMATCH at %0t: %s", $time, msg);
	endtask

	function automatic logic blank_char(input logic [7:0] c);
		return (c == B_SP) || (c == B_TAB) || (c == B_VT) || (c == B_FF) || (c == CH_CR);
	endfunction

	task automatic restart_line();
		ph        = PH_NAME_LEAD;
		kind      = KIND_NONE;
		key_pos   = '0;
		acc       = '0;
		saw_digit = 1'b0;
		ovf       = 1'b0;
	endtask

	task automatic take_digit(input logic [7:0] c);
		logic [63:0] d;
		logic [63:0] lmax;
		logic [63:0] acc_w;
		d     = {56'd0, c - CH_ZERO};
		lmax  = (64'd1 << LENGTH_BITS) - 64'd1;
		acc_w = {{(64-LENGTH_BITS){1'b0}}, acc};
		// once past the length range the value is dead, later digits change nothing
		if (!ovf) begin
			if (acc_w > (lmax - d) / 64'd10)
				ovf = 1'b1;
			else
				acc = acc * 10 + d[LENGTH_BITS-1:0];
		end
		saw_digit = 1'b1;
	endtask

	// one accepted byte through the deframer; payload bytes queue an expected item
	task automatic deframe_byte(input logic [7:0] c);
		item_t r;
		int    k;
		if (pl_mode) begin
			left   = left - 1'b1;
			r.data = c;
			r.last = (left == '0);
			expected_payload.push_back(r);
			if (r.last) begin
				pl_mode  = 1'b0;
				pend_len = '0;
				restart_line();
			end
		end else if (c == CH_LF) begin
			if (kind != KIND_TEXT) begin
				// empty line (or lone CR) closes the header block
				if (pend_len != '0) begin
					pl_mode = 1'b1;
					left    = pend_len;
				end
			end else if (ph == PH_VAL_LEAD || ph == PH_VAL_DIGITS || ph == PH_VAL_DONE) begin
				pend_len = (saw_digit && !ovf) ? acc : '0;
			end
			restart_line();
		end else begin
			kind = (kind == KIND_NONE && c == CH_CR) ? KIND_CR : KIND_TEXT;
			case (ph)
				PH_NAME_LEAD, PH_NAME_BODY, PH_NAME_TRAIL, PH_NAME_FAIL: begin
					if (c == CH_COLON) begin
						ph = (ph != PH_NAME_FAIL && key_pos == KEY_LEN) ? PH_VAL_LEAD : PH_IGNORE;
					end else if (ph != PH_NAME_FAIL) begin
						k = KEY_LEN - 1 - int'(key_pos);
						if (blank_char(c)) begin
							if (ph == PH_NAME_BODY)
								ph = PH_NAME_TRAIL;
						end else if (ph == PH_NAME_TRAIL) begin
							ph = PH_NAME_FAIL;
						end else if (key_pos < KEY_LEN && c == CL_KEY[8*k +: 8]) begin
							key_pos = key_pos + 1'b1;
							ph      = PH_NAME_BODY;
						end else begin
							ph = PH_NAME_FAIL;
						end
					end
				end
				PH_VAL_LEAD: begin
					if (c >= CH_ZERO && c <= CH_NINE) begin
						take_digit(c);
						ph = PH_VAL_DIGITS;
					end else if (!blank_char(c)) begin
						ph = PH_VAL_DONE;
					end
				end
				PH_VAL_DIGITS: begin
					if (c >= CH_ZERO && c <= CH_NINE)
						take_digit(c);
					else
						ph = PH_VAL_DONE;
				end
				default: ;
			endcase
		end
	endtask

	// stream builders
	task automatic put_text(input string s);
		for (int i = 0; i < s.len(); i++)
			byte_stream.push_back(s[i]);
	endtask

	task automatic end_line(input bit crlf);
		if (crlf)
			byte_stream.push_back(CH_CR);
		byte_stream.push_back(CH_LF);
	endtask

	task automatic put_line(input string s, input bit crlf);
		put_text(s);
		end_line(crlf);
	endtask

	task automatic put_payload(input int n);
		repeat (n) byte_stream.push_back(8'($urandom_range(255)));
	endtask

	task automatic put_blanks(input int max_n);
		int pick;
		repeat ($urandom_range(max_n)) begin
			pick = $urandom_range(4);
			case (pick)
				0:       byte_stream.push_back(B_SP);
				1:       byte_stream.push_back(B_TAB);
				2:       byte_stream.push_back(B_VT);
				3:       byte_stream.push_back(B_FF);
				default: byte_stream.push_back(CH_CR);
			endcase
		end
	endtask

	task automatic length_header(input string value);
		put_blanks(2);
		put_text("Content-Length");
		put_blanks(2);
		byte_stream.push_back(CH_COLON);
		put_blanks(2);
		put_text(value);
		if ($urandom_range(3) == 0)
			put_text(" ; q=1");
		end_line(1'($urandom_range(1)));
	endtask

	task automatic noise_header();
		bit crlf;
		crlf = 1'($urandom_range(1));
		case ($urandom_range(6))
			0:       put_line("Host: example", crlf);
			1:       put_line("Content-Type: text/plain", crlf);
			2:       put_line("content-length: 7", crlf);
			3:       put_line("Content-Lengths: 7", crlf);
			4:       put_line("Content-Length 7", crlf);
			5:       put_line("X-Hint: Content-Length: 7", crlf);
			default: put_line("Content Length: 7", crlf);
		endcase
	endtask

	// driver: holds the item while full, otherwise idles at random outside the calm stretch
	always @(posedge clk) begin
		if (!arst_n) begin
			push <= 1'b0;
		end else begin
			if (push && !full) begin
				deframe_byte(in_byte);
				byte_stream.delete(0);
				accepted_bytes <= accepted_bytes + 1;
			end
			if (!(push && full)) begin
				if (byte_stream.size() != 0 && (calm || $urandom_range(99) >= IDLE_PCT)) begin
					push    <= 1'b1;
					in_byte <= byte_stream[0];
				end else begin
					push <= 1'b0;
				end
			end
		end
	end

	// monitor: scoreboard against the oldest expected item
	always @(posedge clk) begin
		item_t want;
		if (!arst_n) begin
			pop <= 1'b0;
		end else begin
			if (pop && !empty) begin
				if (expected_payload.size() == 0) begin
					note_mismatch($sformatf("item %02h last=%0b with none expected",
						payload_byte, payload_last));
				end else begin
					want = expected_payload.pop_front();
					if (payload_byte !== want.data)
						note_mismatch($sformatf("payload_byte %02h, expected %02h",
							payload_byte, want.data));
					if (payload_last !== want.last)
						note_mismatch($sformatf("payload_last %0b, expected %0b (byte %02h)",
							payload_last, want.last, want.data));
				end
			end
			pop <= calm || ($urandom_range(99) >= IDLE_PCT);
		end
	end

	always @(posedge clk) begin
		if ((push && !full) || (pop && !empty)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles == WATCHDOG_LIMIT) begin
			$display("content_length_deframer verification failed");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		int    dir_n;
		int    pick;
		int    n;
		string v;

		// shortest payload, byte zero
		put_line("Content-Length: 1", 1'b0);
		end_line(1'b0);
		byte_stream.push_back(8'h00);
		// CRLF framing; line feed and carriage return as payload
		put_line("Content-Length:2", 1'b1);
		end_line(1'b1);
		byte_stream.push_back(CH_LF);
		byte_stream.push_back(CH_CR);
		// blanks around name and value, trailing text, ignored lines
		byte_stream.push_back(B_SP);
		byte_stream.push_back(B_SP);
		put_text("Content-Length");
		byte_stream.push_back(B_TAB);
		put_text(": ");
		byte_stream.push_back(B_VT);
		put_text("3 xyz");
		end_line(1'b1);
		put_line("Host: a", 1'b0);
		put_line("no colon here", 1'b0);
		end_line(1'b0);
		byte_stream.push_back(8'hFF);
		byte_stream.push_back(8'h00);
		byte_stream.push_back(8'h80);
		// largest length, then overridden by a later header
		put_line("Content-Length: 4294967295", 1'b0);
		put_line("Content-Length: 2", 1'b0);
		end_line(1'b0);
		put_payload(2);
		// overflow, signs, missing digits: all give zero
		put_line("Content-Length: 4294967296", 1'b0);
		end_line(1'b0);
		put_line("Content-Length: +5", 1'b0);
		end_line(1'b0);
		put_line("Content-Length: -5", 1'b1);
		end_line(1'b1);
		put_line("Content-Length:", 1'b0);
		end_line(1'b0);
		// names that must not match
		put_line("Content -Length: 5", 1'b0);
		put_line("content-length: 5", 1'b0);
		put_line("Content-Lengthx: 5", 1'b0);
		put_line("Content-Len: 5", 1'b0);
		put_line("X: Content-Length: 5", 1'b0);
		end_line(1'b0);
		// only the first colon splits; a blank-only line and CR CR LF are not empty
		put_line("Content-Length: 1:9", 1'b0);
		put_line(" ", 1'b0);
		byte_stream.push_back(CH_CR);
		end_line(1'b1);
		end_line(1'b1);
		byte_stream.push_back(8'h7F);
		// leading zeros, form feeds
		byte_stream.push_back(B_FF);
		put_text("Content-Length:007");
		byte_stream.push_back(B_FF);
		end_line(1'b0);
		end_line(1'b0);
		put_payload(7);
		// explicit zero at the blank line
		put_line("Content-Length: 0", 1'b1);
		end_line(1'b1);

		dir_n = byte_stream.size();
		while (byte_stream.size() < dir_n + RANDOM_BYTES) begin
			pick = $urandom_range(99);
			if (pick < 75) begin
				n = ($urandom_range(9) == 0) ? $urandom_range(48, 17) : $urandom_range(16, 1);
				repeat ($urandom_range(2)) noise_header();
				if ($urandom_range(4) == 0)
					length_header($sformatf("%0d", $urandom_range(99999)));
				v = $sformatf("%0d", n);
				if ($urandom_range(3) == 0)
					v = {"00", v};
				length_header(v);
				repeat ($urandom_range(1)) noise_header();
				end_line(1'($urandom_range(1)));
				put_payload(n);
			end else if (pick < 90) begin
				// header block that ends with zero length
				if ($urandom_range(1))
					length_header($sformatf("%0d", $urandom_range(40, 1)));
				case ($urandom_range(4))
					0:       length_header("abc");
					1:       length_header("-3");
					2:       length_header("99999999999");
					3:       length_header("");
					default: length_header("0");
				endcase
				end_line(1'($urandom_range(1)));
			end else begin
				repeat ($urandom_range(12, 1)) byte_stream.push_back(8'($urandom_range(255)));
				end_line(1'b0);
			end
		end

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		while (byte_stream.size() != 0 || push)
			@(posedge clk);
		while (expected_payload.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);

		if (mismatches == 0)
			$display("content_length_deframer verification clean");
		else
			$display("content_length_deframer verification failed");
		$finish;
	end

endmodule

// ===== content_length_deframer.f =====
hw/rtl/cld_pkg.sv
hw/rtl/cld_parser.sv
hw/rtl/cld_queue.sv
hw/rtl/content_length_deframer.sv
dv/content_length_deframer_tb.sv
